// ===== src/psf_pkg.sv =====
package psf_pkg;

  // Fixed-point format
  localparam int unsigned FRAC_BITS_DEF = 16;
  localparam int unsigned CFG_W         = 31;
  localparam int unsigned ADDR_W        = 5;

  // Register map, word index taken from paddr[4:2]
  localparam logic [2:0] REG_SPRING_K = 3'd0;
  localparam logic [2:0] REG_REST_LEN = 3'd1;
  localparam logic [2:0] REG_BOX_X    = 3'd2;
  localparam logic [2:0] REG_BOX_Y    = 3'd3;
  localparam logic [2:0] REG_BOX_Z    = 3'd4;

  // Input word: two bead positions
  typedef struct packed {
    logic signed [31:0] pos_a_x;
    logic signed [31:0] pos_a_y;
    logic signed [31:0] pos_a_z;
    logic signed [31:0] pos_b_x;
    logic signed [31:0] pos_b_y;
    logic signed [31:0] pos_b_z;
  } pair_in_t;

  // Output word: force on bead A, separation and zero-distance flag
  typedef struct packed {
    logic signed [31:0] force_x;
    logic signed [31:0] force_y;
    logic signed [31:0] force_z;
    logic        [31:0] separation;
    logic               zero_distance;
  } pair_out_t;

endpackage

// ===== src/periodic_spring_pair_force_top.sv =====
// Harmonic spring force between two beads in a periodic box.
// Input channel: in_valid_i / in_stall_o carry one pair_in_t word (both bead
// positions). Output channel: out_valid_o / out_stall_i carry one pair_out_t
// word (force on bead A, minimum-image separation, coincidence flag). Bead B
// takes the negated force.
// Throughput: one word per cycle while in_stall_o is low. The pipeline depth
// is set by the three minimum-image remainder units (17 stages, 2 bits a
// stage), the square root (16 stages, 2 result bits a stage) and the three
// force dividers (16 stages, 2 quotient bits a stage). Registers must be
// written over the APB port with no word in flight; the block does not check.
// Reset clears all valid bits and the two-entry output buffer and loads the
// default registers (k = 1.0, rest length = 1.0, box lengths = 100.0).
// When the receiver stalls, the finished word holds on out_word_o and one more
// word is parked in the skid entry; only then does in_stall_o rise and the
// whole pipeline freeze, so nothing is lost or repeated.
module periodic_spring_pair_force_top
  import psf_pkg::*;
#(
  parameter int unsigned FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  pair_in_t          in_word_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output pair_out_t         out_word_o,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  localparam int unsigned NUM_W  = 34;
  localparam int unsigned MOD_ST = NUM_W / 2;
  localparam int unsigned SQ_ST  = 16;
  localparam int unsigned DIV_ST = 16;

  typedef struct packed {
    logic [NUM_W-1:0] num;
    logic [31:0]      rem;
    logic             neg;
    logic [31:0]      sat;
  } fold_lane_t;

  typedef struct packed {
    logic [2:0][31:0] a;
    logic [2:0]       pos;
    logic             zero;
  } side_t;

  typedef struct packed {
    logic [63:0] x;
    logic [32:0] rem;
    logic [31:0] root;
    side_t       side;
  } sqrt_t;

  typedef struct packed {
    logic [31:0] sep;
    logic [31:0] stretch;
    logic        longer;
    side_t       side;
  } stretch_t;

  typedef struct packed {
    logic [2:0][31:0] rem;
    logic [2:0][31:0] lo;
    logic [2:0][31:0] q;
    logic [31:0]      sep;
    logic [31:0]      stretch;
    logic             longer;
    logic [2:0]       pos;
    logic             zero;
  } div_t;

  typedef struct packed {
    logic [2:0][62:0] kt;
    logic [31:0]      sep;
    logic             longer;
    logic [2:0]       pos;
    logic             zero;
  } kt_t;

  // One restoring remainder step
  function automatic logic [31:0] mod_bit(input logic [31:0] rem, input logic b,
                                          input logic [31:0] den);
    logic [32:0] sh;
    sh = {rem, b};
    if (sh >= {1'b0, den}) sh = sh - {1'b0, den};
    return sh[31:0];
  endfunction

  function automatic fold_lane_t mod_pair(input fold_lane_t l, input logic [31:0] den);
    fold_lane_t r;
    r     = l;
    r.rem = mod_bit(mod_bit(l.rem, l.num[NUM_W-1], den), l.num[NUM_W-2], den);
    r.num = {l.num[NUM_W-3:0], 2'b00};
    return r;
  endfunction

  // Two digit-by-digit square root iterations
  function automatic sqrt_t sqrt_pair(input sqrt_t s);
    sqrt_t       r;
    logic [34:0] sh;
    logic [33:0] trial;
    r = s;
    for (int i = 0; i < 2; i++) begin
      sh    = {r.rem, r.x[63:62]};
      trial = {r.root, 2'b01};
      r.x   = {r.x[61:0], 2'b00};
      if (sh >= {1'b0, trial}) begin
        r.rem  = 33'(sh - {1'b0, trial});
        r.root = {r.root[30:0], 1'b1};
      end else begin
        r.rem  = sh[32:0];
        r.root = {r.root[30:0], 1'b0};
      end
    end
    return r;
  endfunction

  // Two restoring division steps on each lane
  function automatic div_t div_pair(input div_t s);
    div_t        r;
    logic [32:0] sh;
    r = s;
    for (int j = 0; j < 3; j++) begin
      for (int i = 0; i < 2; i++) begin
        sh      = {r.rem[j], r.lo[j][31]};
        r.lo[j] = {r.lo[j][30:0], 1'b0};
        if (sh >= {1'b0, r.sep}) begin
          r.rem[j] = 32'(sh - {1'b0, r.sep});
          r.q[j]   = {r.q[j][30:0], 1'b1};
        end else begin
          r.rem[j] = sh[31:0];
          r.q[j]   = {r.q[j][30:0], 1'b0};
        end
      end
    end
    return r;
  endfunction

  // ---------------------------------------------------------------
  // Register file
  logic [CFG_W-1:0]      k_q, rest_q;
  logic [2:0][CFG_W-1:0] box_q;
  logic                  cfg_wr;

  assign cfg_wr = psel && penable && pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      k_q    <= CFG_W'(1) << FRAC_BITS;
      rest_q <= CFG_W'(1) << FRAC_BITS;
      box_q  <= {3{CFG_W'(100) << FRAC_BITS}};
    end else if (cfg_wr) begin
      unique case (paddr[4:2])
        REG_SPRING_K: k_q      <= pwdata[CFG_W-1:0];
        REG_REST_LEN: rest_q   <= pwdata[CFG_W-1:0];
        REG_BOX_X:    box_q[0] <= pwdata[CFG_W-1:0];
        REG_BOX_Y:    box_q[1] <= pwdata[CFG_W-1:0];
        REG_BOX_Z:    box_q[2] <= pwdata[CFG_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[4:2])
      REG_SPRING_K: prdata = {1'b0, k_q};
      REG_REST_LEN: prdata = {1'b0, rest_q};
      REG_BOX_X:    prdata = {1'b0, box_q[0]};
      REG_BOX_Y:    prdata = {1'b0, box_q[1]};
      REG_BOX_Z:    prdata = {1'b0, box_q[2]};
      default:      prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------
  // Pipeline advance: frozen only while the output buffer is full
  logic [1:0] cnt_q, cnt_d;
  logic       en;

  assign en         = (cnt_q != 2'd2);
  assign in_stall_o = !en;

  // ---------------------------------------------------------------
  // Entry: displacement and 2d + L folded to sign and magnitude
  logic [2:0][31:0] pa, pb;
  fold_lane_t [2:0] mod0_d;
  fold_lane_t [2:0] mod_q [0:MOD_ST];
  logic             mod_v_q [0:MOD_ST];

  assign pa = {in_word_i.pos_a_z, in_word_i.pos_a_y, in_word_i.pos_a_x};
  assign pb = {in_word_i.pos_b_z, in_word_i.pos_b_y, in_word_i.pos_b_x};

  always_comb begin
    logic [32:0] d;
    logic [34:0] num;
    logic [34:0] mag;
    for (int j = 0; j < 3; j++) begin
      d             = {pa[j][31], pa[j]} - {pb[j][31], pb[j]};
      num           = {d[32], d, 1'b0} + {4'b0, box_q[j]};
      mag           = num[34] ? (35'd0 - num) : num;
      mod0_d[j].num = mag[NUM_W-1:0];
      mod0_d[j].rem = '0;
      mod0_d[j].neg = num[34];
      if (d[32] != d[31]) mod0_d[j].sat = d[32] ? 32'h8000_0000 : 32'h7FFF_FFFF;
      else                mod0_d[j].sat = d[31:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni)  mod_v_q[0] <= 1'b0;
    else if (en) mod_v_q[0] <= in_valid_i;
  end

  always_ff @(posedge clk_i) begin
    if (en) mod_q[0] <= mod0_d;
  end

  // Remainder of |2d + L| by 2L, two bits a stage
  for (genvar g = 1; g <= MOD_ST; g++) begin : g_mod
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni)  mod_v_q[g] <= 1'b0;
      else if (en) mod_v_q[g] <= mod_v_q[g-1];
    end
    always_ff @(posedge clk_i) begin
      if (en) begin
        for (int j = 0; j < 3; j++) begin
          mod_q[g][j] <= mod_pair(mod_q[g-1][j], {box_q[j], 1'b0});
        end
      end
    end
  end

  // ---------------------------------------------------------------
  // Fold finish: floor remainder, d' = (rem - L) / 2
  logic [2:0][31:0] fd_d, fd_q;
  logic             f_v_q;

  always_comb begin
    logic [31:0] den;
    logic [31:0] r;
    logic [32:0] diff;
    for (int j = 0; j < 3; j++) begin
      den  = {box_q[j], 1'b0};
      r    = (mod_q[MOD_ST][j].neg && mod_q[MOD_ST][j].rem != '0) ?
             den - mod_q[MOD_ST][j].rem : mod_q[MOD_ST][j].rem;
      diff = {1'b0, r} - {2'b0, box_q[j]};
      fd_d[j] = (box_q[j] == '0) ? mod_q[MOD_ST][j].sat : diff[32:1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni)  f_v_q <= 1'b0;
    else if (en) f_v_q <= mod_v_q[MOD_ST];
  end

  always_ff @(posedge clk_i) begin
    if (en) fd_q <= fd_d;
  end

  // ---------------------------------------------------------------
  // Magnitudes and signs
  side_t a_d, a_q;
  logic  a_v_q;

  always_comb begin
    for (int j = 0; j < 3; j++) begin
      a_d.a[j]   = fd_q[j][31] ? (32'd0 - fd_q[j]) : fd_q[j];
      a_d.pos[j] = !fd_q[j][31];
    end
    a_d.zero = (fd_q == '0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni)  a_v_q <= 1'b0;
    else if (en) a_v_q <= f_v_q;
  end

  always_ff @(posedge clk_i) begin
    if (en) a_q <= a_d;
  end

  // ---------------------------------------------------------------
  // Squares
  logic [2:0][63:0] sq_q;
  side_t            sq_side_q;
  logic             sq_v_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni)  sq_v_q <= 1'b0;
    else if (en) sq_v_q <= a_v_q;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int j = 0; j < 3; j++) sq_q[j] <= 64'(a_q.a[j]) * 64'(a_q.a[j]);
      sq_side_q <= a_q;
    end
  end

  // ---------------------------------------------------------------
  // Sum of squares, then square root two bits a stage
  sqrt_t sr_q [0:SQ_ST];
  logic  sr_v_q [0:SQ_ST];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni)  sr_v_q[0] <= 1'b0;
    else if (en) sr_v_q[0] <= sq_v_q;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      sr_q[0].x    <= sq_q[0] + sq_q[1] + sq_q[2];
      sr_q[0].rem  <= '0;
      sr_q[0].root <= '0;
      sr_q[0].side <= sq_side_q;
    end
  end

  for (genvar g = 1; g <= SQ_ST; g++) begin : g_sqrt
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni)  sr_v_q[g] <= 1'b0;
      else if (en) sr_v_q[g] <= sr_v_q[g-1];
    end
    always_ff @(posedge clk_i) begin
      if (en) sr_q[g] <= sqrt_pair(sr_q[g-1]);
    end
  end

  // ---------------------------------------------------------------
  // Stretch against rest length
  stretch_t st_d, st_q;
  logic     st_v_q;

  always_comb begin
    logic [32:0] diff;
    diff         = {1'b0, sr_q[SQ_ST].root} - {2'b0, rest_q};
    st_d.sep     = sr_q[SQ_ST].root;
    st_d.longer  = !diff[32];
    st_d.stretch = diff[32] ? (32'd0 - diff[31:0]) : diff[31:0];
    st_d.side    = sr_q[SQ_ST].side;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni)  st_v_q <= 1'b0;
    else if (en) st_v_q <= sr_v_q[SQ_ST];
  end

  always_ff @(posedge clk_i) begin
    if (en) st_q <= st_d;
  end

  // ---------------------------------------------------------------
  // stretch * |d'|, then divide by distance two bits a stage
  div_t dv_d;
  div_t dv_q [0:DIV_ST];
  logic dv_v_q [0:DIV_ST];

  always_comb begin
    logic [63:0] p;
    for (int j = 0; j < 3; j++) begin
      p            = 64'(st_q.stretch) * 64'(st_q.side.a[j]);
      dv_d.rem[j]  = p[63:32];
      dv_d.lo[j]   = p[31:0];
      dv_d.q[j]    = '0;
    end
    dv_d.sep     = st_q.sep;
    dv_d.stretch = st_q.stretch;
    dv_d.longer  = st_q.longer;
    dv_d.pos     = st_q.side.pos;
    dv_d.zero    = st_q.side.zero;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni)  dv_v_q[0] <= 1'b0;
    else if (en) dv_v_q[0] <= st_v_q;
  end

  always_ff @(posedge clk_i) begin
    if (en) dv_q[0] <= dv_d;
  end

  for (genvar g = 1; g <= DIV_ST; g++) begin : g_div
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni)  dv_v_q[g] <= 1'b0;
      else if (en) dv_v_q[g] <= dv_v_q[g-1];
    end
    always_ff @(posedge clk_i) begin
      if (en) dv_q[g] <= div_pair(dv_q[g-1]);
    end
  end

  // ---------------------------------------------------------------
  // k * t
  kt_t  kt_q;
  logic kt_v_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni)  kt_v_q <= 1'b0;
    else if (en) kt_v_q <= dv_v_q[DIV_ST];
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int j = 0; j < 3; j++) kt_q.kt[j] <= 63'(k_q) * 63'(dv_q[DIV_ST].q[j]);
      kt_q.sep    <= dv_q[DIV_ST].sep;
      kt_q.longer <= dv_q[DIV_ST].longer;
      kt_q.pos    <= dv_q[DIV_ST].pos;
      kt_q.zero   <= dv_q[DIV_ST].zero;
    end
  end

  // ---------------------------------------------------------------
  // Scale, sign, saturate
  pair_out_t        res;
  logic [2:0][31:0] frc;

  always_comb begin
    logic [62:0] f;
    for (int j = 0; j < 3; j++) begin
      f = kt_q.kt[j] >> FRAC_BITS;
      if (kt_q.longer == kt_q.pos[j]) begin
        frc[j] = (f > 63'h8000_0000) ? 32'h8000_0000 : (32'd0 - f[31:0]);
      end else begin
        frc[j] = (f > 63'h7FFF_FFFF) ? 32'h7FFF_FFFF : f[31:0];
      end
    end
    if (kt_q.zero) begin
      res = '0;
      res.zero_distance = 1'b1;
    end else begin
      res.force_x       = frc[0];
      res.force_y       = frc[1];
      res.force_z       = frc[2];
      res.separation    = kt_q.sep;
      res.zero_distance = 1'b0;
    end
  end

  // ---------------------------------------------------------------
  // Output register with one skid entry
  pair_out_t e0_q, e1_q;
  logic      push, pop;

  assign push = en && kt_v_q;
  assign pop  = (cnt_q != 2'd0) && !out_stall_i;

  always_comb begin
    cnt_d = cnt_q;
    unique case (cnt_q)
      2'd0:    if (push) cnt_d = 2'd1;
      2'd1:    if (push && !pop) cnt_d = 2'd2;
               else if (!push && pop) cnt_d = 2'd0;
      2'd2:    if (pop) cnt_d = 2'd1;
      default: cnt_d = 2'd0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) cnt_q <= 2'd0;
    else         cnt_q <= cnt_d;
  end

  always_ff @(posedge clk_i) begin
    if (cnt_q == 2'd2) begin
      if (pop) e0_q <= e1_q;
    end else if (push) begin
      if (cnt_q == 2'd0 || pop) e0_q <= res;
      else                      e1_q <= res;
    end
  end

  assign out_valid_o = (cnt_q != 2'd0);
  assign out_word_o  = e0_q;

  // ---------------------------------------------------------------
  // Checks
  logic signed [33:0] two_dx, len_x;

  assign two_dx = {fd_q[0][31], fd_q[0], 1'b0};
  assign len_x  = {3'b0, box_q[0]};

  // folded x component lies in [-L/2, L/2)
  a_fold_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (f_v_q && box_q[0] != '0) |-> ((two_dx >= -len_x) && (two_dx < len_x)))
    else $error("folded x component outside half box");

  // quotient of stretch*a/dist never exceeds stretch
  a_div_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (dv_v_q[DIV_ST] && !dv_q[DIV_ST].zero) |->
      ((dv_q[DIV_ST].q[0] <= dv_q[DIV_ST].stretch) &&
       (dv_q[DIV_ST].q[1] <= dv_q[DIV_ST].stretch) &&
       (dv_q[DIV_ST].q[2] <= dv_q[DIV_ST].stretch)))
    else $error("force divider quotient above stretch");

  // coinciding beads give an all-zero word
  a_zero_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_word_o.zero_distance) |->
      (out_word_o.separation == '0 && out_word_o.force_x == '0 &&
       out_word_o.force_y == '0 && out_word_o.force_z == '0))
    else $error("zero-distance word carries data");

  // distinct beads have a non-zero separation
  a_sep_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_word_o.zero_distance) |-> (out_word_o.separation != '0))
    else $error("zero separation without flag");

  // a full buffer freezes the pipeline until a word leaves
  a_full_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == 2'd2 && out_stall_i) |=> (cnt_q == 2'd2))
    else $error("output buffer drained while stalled");

endmodule
